// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl core
// no dependencies; clock clk and reset arst_n must be in scope where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define FII_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FII_ASSERT_IMPL(label, ante, cons, msg) \
	`FII_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/fii_pkg.sv =====
// package for the fresnel integral interpolator: defaults, control word type and tables
// no dependencies
package fii_pkg;

	localparam int unsigned FRACTION_BITS_DEF = 16;
	localparam int unsigned TABLE_ENTRIES_DEF = 72;
	localparam int unsigned STORED_ROWS       = 72;
	localparam int unsigned SCALE_FACTOR      = 50;
	localparam longint unsigned DEC_SCALE     = 64'd10000000000;

	localparam logic FUNC_COS = 1'b0;
	localparam logic FUNC_SIN = 1'b1;

	typedef struct packed {
		logic neg;
		logic oor;
	} fii_ctl_t;

	// entries in units of 1e-10, spacing 0.02
	localparam longint unsigned COS_ROWS [STORED_ROWS] = '{
		64'd0, 64'd200000000, 64'd400000000, 64'd600000000, 64'd799990000,
		64'd999980000, 64'd1199900000, 64'd1399900000, 64'd1599700000, 64'd1799500000,
		64'd1999200000, 64'd2198700000, 64'd2398000000, 64'd2597100000, 64'd2795800000,
		64'd2994000000, 64'd3191700000, 64'd3388800000, 64'd3585100000, 64'd3780500000,
		64'd3974800000, 64'd4167900000, 64'd4359500000, 64'd4549400000, 64'd4737500000,
		64'd4923400000, 64'd5107000000, 64'd5287800000, 64'd5465600000, 64'd5640100000,
		64'd5811000000, 64'd5977700000, 64'd6140100000, 64'd6297600000, 64'd6449900000,
		64'd6596500000, 64'd6737000000, 64'd6870900000, 64'd6997800000, 64'd7117100000,
		64'd7228400000, 64'd7331300000, 64'd7425200000, 64'd7509600000, 64'd7584100000,
		64'd7648200000, 64'd7701600000, 64'd7743700000, 64'd7774200000, 64'd7792700000,
		64'd7798900000, 64'd7792600000, 64'd7773500000, 64'd7741400000, 64'd7696300000,
		64'd7638100000, 64'd7566800000, 64'd7482500000, 64'd7385500000, 64'd7276000000,
		64'd7154400000, 64'd7021200000, 64'd6876900000, 64'd6722400000, 64'd6558300000,
		64'd6385500000, 64'd6205100000, 64'd6018200000, 64'd5826000000, 64'd5629800000,
		64'd5431000000, 64'd5231100000
	};

	localparam longint unsigned SIN_ROWS [STORED_ROWS] = '{
		64'd0, 64'd41888, 64'd335100, 64'd1131000, 64'd2680800,
		64'd5235900, 64'd9047500, 64'd14367000, 64'd21444000, 64'd30531000,
		64'd41876000, 64'd55730000, 64'd72340000, 64'd91954000, 64'd114820000,
		64'd141170000, 64'd171260000, 64'd205310000, 64'd243570000, 64'd286260000,
		64'd333590000, 64'd385800000, 64'd443080000, 64'd505640000, 64'd573660000,
		64'd647320000, 64'd726790000, 64'd812210000, 64'd903710000, 64'd1001400000,
		64'd1105400000, 64'd1215800000, 64'd1332500000, 64'd1455700000, 64'd1585400000,
		64'd1721400000, 64'd1863700000, 64'd2012200000, 64'd2166800000, 64'd2327300000,
		64'd2493400000, 64'd2664900000, 64'd2841500000, 64'd3022800000, 64'd3208400000,
		64'd3397800000, 64'd3590500000, 64'd3786000000, 64'd3983600000, 64'd4182700000,
		64'd4382600000, 64'd4582500000, 64'd4781500000, 64'd4978900000, 64'd5173700000,
		64'd5365000000, 64'd5551800000, 64'd5733100000, 64'd5908000000, 64'd6075300000,
		64'd6234000000, 64'd6383100000, 64'd6521600000, 64'd6648500000, 64'd6762700000,
		64'd6863300000, 64'd6949600000, 64'd7020500000, 64'd7075600000, 64'd7114000000,
		64'd7135300000, 64'd7139000000
	};

	// table entry in q0.fb, rounded half up; rows past the stored ones read as zero
	// only ever called with constant arguments
	function automatic longint unsigned entry_fixed(input logic func, input int unsigned idx,
			input int unsigned fb);
		longint unsigned row;
		if (idx >= STORED_ROWS) begin
			return 64'd0;
		end
		row = (func == FUNC_SIN) ? SIN_ROWS[idx] : COS_ROWS[idx];
		return ((row << fb) + DEC_SCALE / 2) / DEC_SCALE;
	endfunction

endpackage

// ===== rtl/core/fresnel_integral_interpolator_top.sv =====
// top level of the fresnel integral interpolator: front stage, control pipeline, two lanes
// depends on fii_pkg, fii_interp and assert_macros.svh
//
// channel  direction  handshake            word
// -------  ---------  -------------------  -------------------------------------------
// in       in         start && !busy       arg (q2.fb, signed)
// out      out        done, one cycle      cos_integral, sin_integral, out_of_range
//
// one word may be taken every cycle; each result follows acceptance through four
// register stages: range split, table read, multiply, add and sign
// busy is held low: the pipeline never stalls, and the receiver cannot hold it off
// arst_n clears the valid bits only; the datapath registers carry no reset
`include "assert_macros.svh"

module fresnel_integral_interpolator_top #(
	parameter int unsigned FRACTION_BITS = fii_pkg::FRACTION_BITS_DEF,
	parameter int unsigned TABLE_ENTRIES = fii_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [FRACTION_BITS+1:0] arg,
	output logic                          done,
	output logic signed [FRACTION_BITS:0] cos_integral,
	output logic signed [FRACTION_BITS:0] sin_integral,
	output logic                          out_of_range
);
	import fii_pkg::*;

	localparam int unsigned FB  = FRACTION_BITS;
	localparam int unsigned AW  = FB + 2;          // argument width
	localparam int unsigned PW  = AW + 6;          // magnitude times the scale factor
	localparam int unsigned XW  = PW - FB;         // full integer part of the product
	localparam int unsigned IW  = $clog2(TABLE_ENTRIES);
	localparam logic [XW-1:0] LAST_IDX = XW'(TABLE_ENTRIES - 1);

	logic            accept;
	logic [AW-1:0]   mag;
	logic [PW-1:0]   prod;
	logic [XW-1:0]   idx_full;
	fii_ctl_t        ctl;

	logic            valid_s1, valid_s2, valid_s3, valid_s4;
	logic [IW-1:0]   idx_s1;
	logic [FB-1:0]   frac_s1;
	fii_ctl_t        ctl_s1, ctl_s2, ctl_s3;
	logic            oor_s4;

	// no back-pressure anywhere in the pipe
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// magnitude: the most negative word maps to 2^(fb+1), which is beyond the table
	assign mag      = arg[AW-1] ? ('0 - $unsigned(arg)) : $unsigned(arg);
	assign prod     = PW'(mag) * PW'(SCALE_FACTOR);
	assign idx_full = prod[PW-1:FB];

	// last usable index is one below the final entry, since entry i+1 is read too
	assign ctl.neg = arg[AW-1];
	assign ctl.oor = (idx_full >= LAST_IDX);

	// valid bits travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 1: index, fraction and control word
	always_ff @(posedge clk) begin
		idx_s1  <= idx_full[IW-1:0];
		frac_s1 <= prod[FB-1:0];
		ctl_s1  <= ctl;
	end

	// control word delayed to meet the lanes' final stage
	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		ctl_s3 <= ctl_s2;
		oor_s4 <= ctl_s3.oor;
	end

	fii_interp #(
		.FRACTION_BITS (FRACTION_BITS),
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.FUNC          (FUNC_COS)
	) u_cos (
		.clk    (clk),
		.idx    (idx_s1),
		.frac   (frac_s1),
		.ctl    (ctl_s3),
		.result (cos_integral)
	);

	fii_interp #(
		.FRACTION_BITS (FRACTION_BITS),
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.FUNC          (FUNC_SIN)
	) u_sin (
		.clk    (clk),
		.idx    (idx_s1),
		.frac   (frac_s1),
		.ctl    (ctl_s3),
		.result (sin_integral)
	);

	assign done         = valid_s4;
	assign out_of_range = oor_s4;

	// every accepted word comes out as a result once it has passed the pipeline
	`FII_ASSERT(a_latency_fwd, accept |-> ##4 done, "accepted word did not produce a result")
	// and no result appears without a word behind it
	`FII_ASSERT_IMPL(a_latency_bwd, done, $past(accept, 4), "result without an accepted word")
	// out of range words give zero results
	`FII_ASSERT_IMPL(a_oor_zero, done && out_of_range,
		(cos_integral == '0) && (sin_integral == '0), "out of range result not zero")
	// odd functions: a non-negative argument never yields a negative result
	`FII_ASSERT_IMPL(a_sign, done && !$past(arg[AW-1], 4),
		!cos_integral[FB] && !sin_integral[FB], "negative result for non-negative argument")

endmodule

// ===== rtl/core/fii_interp.sv =====
// table lookup and linear interpolation for one fresnel integral, stages 2 to 4
// depends on fii_pkg
module fii_interp #(
	parameter int unsigned FRACTION_BITS = fii_pkg::FRACTION_BITS_DEF,
	parameter int unsigned TABLE_ENTRIES = fii_pkg::TABLE_ENTRIES_DEF,
	parameter logic        FUNC          = fii_pkg::FUNC_COS
) (
	input  logic                                clk,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]    idx,
	input  logic [FRACTION_BITS-1:0]            frac,
	input  fii_pkg::fii_ctl_t                   ctl,
	output logic signed [FRACTION_BITS:0]       result
);
	import fii_pkg::*;

	localparam int unsigned FB = FRACTION_BITS;
	localparam int unsigned IW = $clog2(TABLE_ENTRIES);
	localparam int unsigned AW = 2 * FB + 2;
	localparam logic [AW-1:0] HALF = AW'(1) << (FB - 1);

	logic [FB-1:0]        tab [TABLE_ENTRIES];
	logic [IW-1:0]        idx_next;
	logic [FB-1:0]        t0_s2;
	logic signed [FB:0]   diff_s2;
	logic [FB-1:0]        frac_s2;
	logic signed [AW-1:0] prod_s3;
	logic [FB-1:0]        t0_s3;
	logic [AW-1:0]        acc;
	logic [FB:0]          mag;
	logic [FB:0]          result_s4;

	// constant table, worked out at elaboration
	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_tab
		localparam logic [FB-1:0] ENTRY = FB'(entry_fixed(FUNC, k, FB));
		assign tab[k] = ENTRY;
	end

	assign idx_next = idx + IW'(1);

	// stage 2: both neighbouring entries
	always_ff @(posedge clk) begin
		t0_s2   <= tab[idx];
		diff_s2 <= $signed({1'b0, tab[idx_next]}) - $signed({1'b0, tab[idx]});
		frac_s2 <= frac;
	end

	// stage 3: slope times fraction
	always_ff @(posedge clk) begin
		prod_s3 <= AW'(diff_s2 * $signed({1'b0, frac_s2}));
		t0_s3   <= t0_s2;
	end

	// sum stays non-negative and below 2^(2fb)
	assign acc = AW'({t0_s3, {FB{1'b0}}}) + $unsigned(prod_s3) + HALF;
	assign mag = {1'b0, acc[2*FB-1:FB]};

	// stage 4: sign and range
	always_ff @(posedge clk) begin
		if (ctl.oor) begin
			result_s4 <= '0;
		end else if (ctl.neg) begin
			result_s4 <= '0 - mag;
		end else begin
			result_s4 <= mag;
		end
	end

	assign result = $signed(result_s4);

endmodule
